// ===== hdl/jbt_pkg.sv =====
// Shared types, token codes and byte classes for the JSON byte tokenizer.
`timescale 1ns / 1ps

package jbt_pkg;

    // Token kinds on the result channel
    localparam logic [3:0] KIND_SPACE  = 4'd0;
    localparam logic [3:0] KIND_LBRACE = 4'd1;
    localparam logic [3:0] KIND_RBRACE = 4'd2;
    localparam logic [3:0] KIND_LBRACK = 4'd3;
    localparam logic [3:0] KIND_RBRACK = 4'd4;
    localparam logic [3:0] KIND_COLON  = 4'd5;
    localparam logic [3:0] KIND_COMMA  = 4'd6;
    localparam logic [3:0] KIND_STRING = 4'd7;
    localparam logic [3:0] KIND_NUMBER = 4'd8;
    localparam logic [3:0] KIND_BOOL   = 4'd9;
    localparam logic [3:0] KIND_NULL   = 4'd10;
    localparam logic [3:0] KIND_ERROR  = 4'd11;

    // Scanner modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_STR  = 2'd1;
    localparam logic [1:0] MODE_NUM  = 2'd2;
    localparam logic [1:0] MODE_LIT  = 2'd3;

    // Characters of interest
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // Literal bytes still due after the leading byte
    localparam logic [2:0] LEFT_TRUE  = 3'd3;
    localparam logic [2:0] LEFT_FALSE = 3'd4;
    localparam logic [2:0] LEFT_NULL  = 3'd3;

    // One result item
    typedef struct packed {
        logic [7:0] data_byte;
        logic [3:0] token_kind;
        logic       token_start;
        logic       token_end;
        logic       is_content;
        logic       number_closed;
        logic       error_flag;
    } result_t;

    function automatic logic is_digit(input logic [7:0] b);
        is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        is_space = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

endpackage

// ===== hdl/json_byte_tokenizer.sv =====
// Byte-serial JSON tokenizer: per-byte token marking with a two-entry output buffer.
`timescale 1ns / 1ps

//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_doc_byte[7:0], s_last_byte
//  m_      | out       | m_valid / m_ready  | m_data_byte, m_token_kind[3:0], m_token_start,
//          |           |                    | m_token_end, m_is_content, m_number_closed,
//          |           |                    | m_error_flag
//
//  One byte per cycle unless the output stalls; results are registered in the buffer.
//  The scanner state update is a single-cycle decode of the byte and the current mode.
//  aresetn is synchronous, active low; it returns the scanner to idle and empties the
//  output buffer. When m_ready is low, one more byte is taken into the skid entry,
//  then s_ready drops until the result side drains.

module json_byte_tokenizer (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_doc_byte,
    input  logic                  s_last_byte,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_data_byte,
    output logic [3:0]            m_token_kind,
    output logic                  m_token_start,
    output logic                  m_token_end,
    output logic                  m_is_content,
    output logic                  m_number_closed,
    output logic                  m_error_flag
);
    import jbt_pkg::*;

    logic [1:0] mode_reg, mode_next;
    logic [2:0] lit_left_reg, lit_left_next;
    logic       prev_bs_reg, prev_bs_next;
    logic       lit_null_reg, lit_null_next;

    jbt_pkg::result_t res;
    jbt_pkg::result_t main_reg, main_next;
    jbt_pkg::result_t skid_reg, skid_next;
    logic             main_valid_reg, main_valid_next;
    logic             skid_valid_reg, skid_valid_next;

    logic in_fire, out_fire;

    assign s_ready  = !skid_valid_reg;
    assign in_fire  = s_valid && s_ready;
    assign m_valid  = main_valid_reg;
    assign out_fire = main_valid_reg && m_ready;

    // Classify the incoming byte and work out the next scanner state
    always_comb begin
        logic [1:0] mode_eff;
        logic [2:0] left_dec;
        logic       done;
        mode_eff      = mode_reg;
        left_dec      = lit_left_reg;
        done          = 1'b0;
        mode_next     = mode_reg;
        lit_left_next = lit_left_reg;
        prev_bs_next  = prev_bs_reg;
        lit_null_next = lit_null_reg;
        res           = '0;
        res.data_byte = s_doc_byte;

        // Continue or close a digit run
        if (mode_reg == MODE_NUM) begin
            if (is_digit(s_doc_byte)) begin
                res.token_kind = KIND_NUMBER;
                res.is_content = 1'b1;
                res.token_end  = s_last_byte;
                done           = 1'b1;
            end else begin
                res.number_closed = 1'b1;
                mode_eff          = MODE_IDLE;
                mode_next         = MODE_IDLE;
            end
        end

        if (!done) begin
            if (mode_eff == MODE_STR) begin
                // Inside a string: honor one-byte escapes
                res.token_kind = KIND_STRING;
                if (prev_bs_reg) begin
                    res.is_content = 1'b1;
                    prev_bs_next   = 1'b0;
                end else if (s_doc_byte == CH_QUOTE) begin
                    res.token_end = 1'b1;
                    mode_next     = MODE_IDLE;
                end else begin
                    res.is_content = 1'b1;
                    prev_bs_next   = (s_doc_byte == CH_BSLASH);
                end
                if (mode_next == MODE_STR && s_last_byte) begin
                    res.token_end  = 1'b1;
                    res.error_flag = 1'b1;
                end
            end else if (mode_eff == MODE_LIT) begin
                // Count down the literal bytes without checking them
                res.token_kind = lit_null_reg ? KIND_NULL : KIND_BOOL;
                res.is_content = 1'b1;
                if (lit_left_reg != 3'd0) begin
                    left_dec = lit_left_reg - 3'd1;
                end
                lit_left_next = left_dec;
                if (left_dec == 3'd0) begin
                    res.token_end = 1'b1;
                    mode_next     = MODE_IDLE;
                end else if (s_last_byte) begin
                    res.token_end  = 1'b1;
                    res.error_flag = 1'b1;
                end
            end else if (is_space(s_doc_byte)) begin
                res.token_kind = KIND_SPACE;
            end else begin
                // Leading byte of a new token
                res.token_start = 1'b1;
                res.is_content  = 1'b1;
                res.token_end   = 1'b1;
                case (s_doc_byte)
                    CH_LBRACE: res.token_kind = KIND_LBRACE;
                    CH_RBRACE: res.token_kind = KIND_RBRACE;
                    CH_LBRACK: res.token_kind = KIND_LBRACK;
                    CH_RBRACK: res.token_kind = KIND_RBRACK;
                    CH_COLON:  res.token_kind = KIND_COLON;
                    CH_COMMA:  res.token_kind = KIND_COMMA;
                    CH_QUOTE: begin
                        res.token_kind = KIND_STRING;
                        res.is_content = 1'b0;
                        res.token_end  = 1'b0;
                        mode_next      = MODE_STR;
                        prev_bs_next   = 1'b0;
                    end
                    CH_T, CH_F, CH_N: begin
                        lit_null_next  = (s_doc_byte == CH_N);
                        res.token_kind = (s_doc_byte == CH_N) ? KIND_NULL : KIND_BOOL;
                        res.token_end  = 1'b0;
                        mode_next      = MODE_LIT;
                        lit_left_next  = (s_doc_byte == CH_T) ? LEFT_TRUE :
                                         (s_doc_byte == CH_F) ? LEFT_FALSE : LEFT_NULL;
                    end
                    default: begin
                        if (is_digit(s_doc_byte)) begin
                            res.token_kind = KIND_NUMBER;
                            res.token_end  = s_last_byte;
                            mode_next      = MODE_NUM;
                        end else begin
                            res.token_kind = KIND_ERROR;
                            res.is_content = 1'b0;
                            res.error_flag = 1'b1;
                        end
                    end
                endcase
                if (s_last_byte && (mode_next == MODE_STR || mode_next == MODE_LIT)) begin
                    res.token_end  = 1'b1;
                    res.error_flag = 1'b1;
                end
            end
        end

        // Final byte: start the next document from scratch
        if (s_last_byte) begin
            mode_next     = MODE_IDLE;
            lit_left_next = 3'd0;
            prev_bs_next  = 1'b0;
            lit_null_next = 1'b0;
        end
    end

    // Advance the scanner on each input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_IDLE;
            lit_left_reg <= 3'd0;
            prev_bs_reg  <= 1'b0;
            lit_null_reg <= 1'b0;
        end else if (in_fire) begin
            mode_reg     <= mode_next;
            lit_left_reg <= lit_left_next;
            prev_bs_reg  <= prev_bs_next;
            lit_null_reg <= lit_null_next;
        end
    end

    // Output register plus skid entry: refill from skid first, else from the new result
    always_comb begin
        main_next       = main_reg;
        skid_next       = skid_reg;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_fire || !main_valid_reg) begin
            main_valid_next = skid_valid_reg || in_fire;
            main_next       = skid_valid_reg ? skid_reg : res;
            skid_valid_next = 1'b0;
        end else if (in_fire) begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign m_data_byte     = main_reg.data_byte;
    assign m_token_kind    = main_reg.token_kind;
    assign m_token_start   = main_reg.token_start;
    assign m_token_end     = main_reg.token_end;
    assign m_is_content    = main_reg.is_content;
    assign m_number_closed = main_reg.number_closed;
    assign m_error_flag    = main_reg.error_flag;

    // The skid entry only fills behind a held output register
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry valid with empty output register");

    // A final byte always leaves the scanner idle
    a_last_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_last_byte) |=> (mode_reg == MODE_IDLE && lit_left_reg == 3'd0))
        else $error("scanner not idle after final byte");

    // Literal mode always has bytes left to take
    a_lit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_LIT) |-> (lit_left_reg != 3'd0))
        else $error("literal mode with zero bytes left");

    // Every error closes its token
    a_error_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_error_flag) |-> m_token_end)
        else $error("error result without token end");

endmodule

// ===== dv/jbt_checker.sv =====
// Token marking predictor and result checker for the JSON byte tokenizer.
`timescale 1ns / 1ps

module jbt_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_doc_byte,
    input  logic       s_last_byte,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_data_byte,
    input  logic [3:0] m_token_kind,
    input  logic       m_token_start,
    input  logic       m_token_end,
    input  logic       m_is_content,
    input  logic       m_number_closed,
    input  logic       m_error_flag,
    output int         marks_pending,
    output int         mark_errors
);
    import jbt_pkg::*;

    // Scanner state as the lexer should hold it
    logic [1:0] scan_state;
    logic [2:0] lit_remaining;
    logic       escape_next;
    logic       lit_null;

    result_t token_marks_q[$];
    int      bad_marks;

    task automatic clear_scanner();
        scan_state    = MODE_IDLE;
        lit_remaining = 3'd0;
        escape_next   = 1'b0;
        lit_null      = 1'b0;
    endtask

    // Work out the marks for one document byte and advance the scanner
    task automatic classify_byte(input logic [7:0] b, input logic last, output result_t r);
        logic taken;
        logic digit;
        logic blank;
        r             = '0;
        r.data_byte   = b;
        taken         = 1'b0;
        digit         = (b >= CH_ZERO) && (b <= CH_NINE);
        blank         = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));

        // Extend a digit run, or close it and lex this byte afresh
        if (scan_state == MODE_NUM) begin
            if (digit) begin
                r.token_kind = KIND_NUMBER;
                r.is_content = 1'b1;
                r.token_end  = last;
                taken        = 1'b1;
            end else begin
                r.number_closed = 1'b1;
                scan_state      = MODE_IDLE;
            end
        end

        if (!taken) begin
            if (scan_state == MODE_STR) begin
                r.token_kind = KIND_STRING;
                if (escape_next) begin
                    r.is_content = 1'b1;
                    escape_next  = 1'b0;
                end else if (b == CH_QUOTE) begin
                    r.token_end = 1'b1;
                    scan_state  = MODE_IDLE;
                end else begin
                    r.is_content = 1'b1;
                    escape_next  = (b == CH_BSLASH);
                end
                if (scan_state == MODE_STR && last) begin
                    r.token_end  = 1'b1;
                    r.error_flag = 1'b1;
                end
            end else if (scan_state == MODE_LIT) begin
                r.token_kind = lit_null ? KIND_NULL : KIND_BOOL;
                r.is_content = 1'b1;
                if (lit_remaining != 3'd0)
                    lit_remaining = lit_remaining - 3'd1;
                if (lit_remaining == 3'd0) begin
                    r.token_end = 1'b1;
                    scan_state  = MODE_IDLE;
                end else if (last) begin
                    r.token_end  = 1'b1;
                    r.error_flag = 1'b1;
                end
            end else if (blank) begin
                r.token_kind = KIND_SPACE;
            end else begin
                r.token_start = 1'b1;
                r.is_content  = 1'b1;
                r.token_end   = 1'b1;
                case (b)
                    CH_LBRACE: r.token_kind = KIND_LBRACE;
                    CH_RBRACE: r.token_kind = KIND_RBRACE;
                    CH_LBRACK: r.token_kind = KIND_LBRACK;
                    CH_RBRACK: r.token_kind = KIND_RBRACK;
                    CH_COLON:  r.token_kind = KIND_COLON;
                    CH_COMMA:  r.token_kind = KIND_COMMA;
                    CH_QUOTE: begin
                        r.token_kind = KIND_STRING;
                        r.is_content = 1'b0;
                        r.token_end  = 1'b0;
                        scan_state   = MODE_STR;
                        escape_next  = 1'b0;
                    end
                    CH_T, CH_F, CH_N: begin
                        lit_null      = (b == CH_N);
                        r.token_kind  = lit_null ? KIND_NULL : KIND_BOOL;
                        r.token_end   = 1'b0;
                        scan_state    = MODE_LIT;
                        lit_remaining = (b == CH_T) ? LEFT_TRUE :
                                        (b == CH_F) ? LEFT_FALSE : LEFT_NULL;
                    end
                    default: begin
                        if (digit) begin
                            r.token_kind = KIND_NUMBER;
                            r.token_end  = last;
                            scan_state   = MODE_NUM;
                        end else begin
                            r.token_kind = KIND_ERROR;
                            r.is_content = 1'b0;
                            r.error_flag = 1'b1;
                        end
                    end
                endcase
                // Document ends on an opening quote or a literal's first byte
                if (last && (scan_state == MODE_STR || scan_state == MODE_LIT)) begin
                    r.token_end  = 1'b1;
                    r.error_flag = 1'b1;
                end
            end
        end

        // Start a new document after the final byte
        if (last)
            clear_scanner();
    endtask

    // Predict on each input transfer, compare on each result transfer
    always @(posedge aclk) begin : watch
        result_t want;
        result_t got;
        if (!aresetn) begin
            clear_scanner();
            token_marks_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                classify_byte(s_doc_byte, s_last_byte, want);
                token_marks_q.push_back(want);
            end
            if (m_valid && m_ready) begin
                got = {m_data_byte, m_token_kind, m_token_start, m_token_end,
                       m_is_content, m_number_closed, m_error_flag};
                if (token_marks_q.size() == 0) begin
                    bad_marks++;
                    if (bad_marks <= 10)
                        $display("%0t: result with nothing pending: byte %h kind %0d",
                                 $realtime, got.data_byte, got.token_kind);
                end else begin
                    want = token_marks_q.pop_front();
                    if (got !== want) begin
                        bad_marks++;
                        if (bad_marks <= 10) begin
                            $write("%0t: mark mismatch exp/act: byte %h/%h kind %0d/%0d ",
                                   $realtime, want.data_byte, got.data_byte,
                                   want.token_kind, got.token_kind);
                            $write("start %b/%b end %b/%b content %b/%b ",
                                   want.token_start, got.token_start,
                                   want.token_end, got.token_end,
                                   want.is_content, got.is_content);
                            $display("nclosed %b/%b err %b/%b",
                                     want.number_closed, got.number_closed,
                                     want.error_flag, got.error_flag);
                        end
                    end
                end
            end
        end
        marks_pending <= token_marks_q.size();
        mark_errors   <= bad_marks;
    end

endmodule

// ===== dv/tb_top.sv =====
// Stimulus, flow control and verdict for the JSON byte tokenizer regression.
`timescale 1ns / 1ps

module tb_top;
    import jbt_pkg::*;

    localparam int RANDOM_BYTES = 1850;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_WAIT  = 20;

    // Receiver stall styles
    localparam int RX_OPEN   = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_SPARSE = 2;
    localparam int RX_STINGY = 3;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic [7:0] s_doc_byte  = 8'h00;
    logic       s_last_byte = 1'b0;
    logic       m_ready     = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic [7:0] m_data_byte;
    logic [3:0] m_token_kind;
    logic       m_token_start;
    logic       m_token_end;
    logic       m_is_content;
    logic       m_number_closed;
    logic       m_error_flag;

    int marks_pending;
    int mark_errors;
    int cycle_cnt   = 0;
    int burst_left  = 0;
    int stall_left  = 0;
    int stall_style = RX_OPEN;

    logic [7:0] doc_bytes[$];

    always #6 aclk = ~aclk;

    json_byte_tokenizer dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_doc_byte      (s_doc_byte),
        .s_last_byte     (s_last_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data_byte     (m_data_byte),
        .m_token_kind    (m_token_kind),
        .m_token_start   (m_token_start),
        .m_token_end     (m_token_end),
        .m_is_content    (m_is_content),
        .m_number_closed (m_number_closed),
        .m_error_flag    (m_error_flag)
    );

    jbt_checker mark_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_doc_byte      (s_doc_byte),
        .s_last_byte     (s_last_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data_byte     (m_data_byte),
        .m_token_kind    (m_token_kind),
        .m_token_start   (m_token_start),
        .m_token_end     (m_token_end),
        .m_is_content    (m_is_content),
        .m_number_closed (m_number_closed),
        .m_error_flag    (m_error_flag),
        .marks_pending   (marks_pending),
        .mark_errors     (mark_errors)
    );

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("json_byte_tokenizer regression: fail");
            $finish;
        end
    end

    // Stall the result side in changing styles
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_style <= $urandom_range(RX_OPEN, RX_STINGY);
            stall_left  <= $urandom_range(32, 300);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_style)
            RX_OPEN:   m_ready <= 1'b1;
            RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_ready <= ($urandom_range(0, 9) != 0);
            default:   m_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Offer one byte and hold it until the transfer
    task automatic push_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 16);
        end
        s_valid     <= 1'b1;
        s_doc_byte  <= b;
        s_last_byte <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
    endtask

    task automatic send_text(input string txt, input logic last_at_end);
        for (int i = 0; i < txt.len(); i++)
            push_byte(txt[i], last_at_end && (i == txt.len() - 1));
    endtask

    // Hold off the sender until every result has come back
    task automatic wait_for_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (marks_pending != 0);
    endtask

    // Build a mostly well-formed document with random content
    task automatic build_random_doc();
        string      lits[3];
        logic [7:0] puncts[6];
        int         n_tok;
        int         pick;
        int         len;
        int         cut;
        logic [7:0] c;
        lits   = '{"true", "false", "null"};
        puncts = '{CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK, CH_COLON, CH_COMMA};
        doc_bytes.delete();
        n_tok = $urandom_range(1, 12);
        repeat (n_tok) begin
            pick = $urandom_range(0, 19);
            if (pick <= 2) begin
                repeat ($urandom_range(1, 3)) begin
                    if ($urandom_range(0, 4) == 0)
                        doc_bytes.push_back(CH_SPACE);
                    else
                        doc_bytes.push_back(CH_TAB + 8'($urandom_range(0, 4)));
                end
            end else if (pick <= 7) begin
                doc_bytes.push_back(puncts[$urandom_range(0, 5)]);
            end else if (pick <= 11) begin
                // string with escapes and arbitrary bytes
                doc_bytes.push_back(CH_QUOTE);
                len = $urandom_range(0, 8);
                repeat (len) begin
                    case ($urandom_range(0, 9))
                        0: begin
                            doc_bytes.push_back(CH_BSLASH);
                            doc_bytes.push_back(8'($urandom_range(0, 255)));
                        end
                        1: begin
                            c = 8'($urandom_range(0, 255));
                            doc_bytes.push_back((c == CH_QUOTE) ? CH_T : c);
                        end
                        default: begin
                            c = 8'($urandom_range(8'h20, 8'h7E));
                            doc_bytes.push_back((c == CH_QUOTE) ? CH_N : c);
                        end
                    endcase
                end
                if ($urandom_range(0, 7) != 0)
                    doc_bytes.push_back(CH_QUOTE);
            end else if (pick <= 14) begin
                repeat ($urandom_range(1, 6))
                    doc_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            end else if (pick <= 17) begin
                len = $urandom_range(0, 2);
                for (int i = 0; i < lits[len].len(); i++) begin
                    if (i > 0 && $urandom_range(0, 5) == 0)
                        doc_bytes.push_back(8'($urandom_range(0, 255)));
                    else
                        doc_bytes.push_back(lits[len][i]);
                end
            end else begin
                doc_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
        // Truncate now and then to end mid-token
        if ($urandom_range(0, 7) == 0 && doc_bytes.size() > 1) begin
            cut = $urandom_range(1, doc_bytes.size() - 1);
            while (doc_bytes.size() > cut) void'(doc_bytes.pop_back());
        end
    endtask

    initial begin : stimulus
        int random_sent;
        random_sent = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: punctuation, escaped quote, doubled backslash, digit run closed
        // by a comma, literal cut by the final byte
        send_text("\t{\"\\\"\\\\\":[12,", 1'b0);
        send_text("n", 1'b1);
        // digit run ending on the final byte
        send_text("9", 1'b1);
        // final byte is an opening quote
        send_text("\"", 1'b1);
        // bad leading bytes, then a document ending inside a string
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        send_text("]}\"a", 1'b1);
        send_text("false\r", 1'b1);
        wait_for_idle();

        // Random documents
        while (random_sent < RANDOM_BYTES) begin
            build_random_doc();
            foreach (doc_bytes[i])
                push_byte(doc_bytes[i], i == doc_bytes.size() - 1);
            random_sent += doc_bytes.size();
            if ($urandom_range(0, 39) == 0)
                wait_for_idle();
        end

        wait_for_idle();
        repeat (SETTLE_WAIT) @(posedge aclk);
        if (mark_errors == 0 && marks_pending == 0)
            $display("json_byte_tokenizer regression: pass");
        else
            $display("json_byte_tokenizer regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/jbt_pkg.sv
hdl/json_byte_tokenizer.sv
dv/jbt_checker.sv
dv/tb_top.sv
